FILE: rtl/core/lwf_pkg.sv
// Shared types, constants and register codes of the wall-follow controller.
`timescale 1ns / 1ps
package lwf_pkg;

  // Scan geometry defaults
  localparam int MAX_SAMPLES        = 1024;
  localparam int SCAN_START_BEARING = -16384;
  localparam int JOB_DEPTH          = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOLLOW_DISTANCE   = 3'd0,
    CFG_BUFFER_DISTANCE   = 3'd1,
    CFG_CRUISE_SPEED      = 3'd2,
    CFG_BEARING_GAIN      = 3'd3,
    CFG_OFFSET_TURN_GAIN  = 3'd4,
    CFG_OFFSET_SPEED_GAIN = 3'd5,
    CFG_WALL_ON_LEFT      = 3'd6,
    CFG_SAMPLE_ANGLE_STEP = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        [13:0] follow_distance;
    logic        [13:0] buffer_distance;
    logic        [10:0] cruise_speed;
    logic signed [15:0] bearing_gain;
    logic signed [15:0] offset_turn_gain;
    logic signed [15:0] offset_speed_gain;
    logic               wall_on_left;
    logic signed [23:0] sample_angle_step;
  } cfg_t;

  // Register reset values
  localparam logic [13:0] FOLLOW_DISTANCE_RST   = 14'd700;
  localparam logic [13:0] BUFFER_DISTANCE_RST   = 14'd400;
  localparam logic [10:0] CRUISE_SPEED_RST      = 11'd500;
  localparam logic [15:0] BEARING_GAIN_RST      = 16'd4096;
  localparam logic [15:0] OFFSET_TURN_GAIN_RST  = 16'd4096;
  localparam logic [15:0] OFFSET_SPEED_GAIN_RST = 16'd2048;
  localparam logic        WALL_ON_LEFT_RST      = 1'b1;
  localparam logic [23:0] SAMPLE_ANGLE_STEP_RST = 24'd46603;

  // Command modes
  typedef enum logic [2:0] {
    MODE_TURN      = 3'd0,
    MODE_APPROACH  = 3'd1,
    MODE_FOLLOW    = 3'd2,
    MODE_BRAKE     = 3'd3,
    MODE_NO_OBJECT = 3'd4
  } mode_e;

  // Control law sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_IDX,
    ST_MUL_GAIN,
    ST_SCALE,
    ST_CLAMP,
    ST_ROUND,
    ST_OUT
  } back_state_e;

  // Range thresholds, mm
  localparam logic [15:0] VALID_MIN_MM = 16'd200;
  localparam logic [15:0] FAR_MM       = 16'd12000;
  localparam logic [15:0] BRAKE_MM     = 16'd150;

  // Command constants
  localparam logic [10:0] SEARCH_SPEED  = 11'd150;
  localparam logic [10:0] APPROACH_TURN = 11'd800;
  localparam logic [10:0] BRAKE_TURN    = 11'd500;
  localparam logic [10:0] SPEED_LIMIT   = 11'd220;

endpackage

FILE: rtl/core/lwf_fifo.sv
// Short request queue between the scan front end and the control law back end.
`timescale 1ns / 1ps
module lwf_fifo #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign data_o  = mem_q[rptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/lwf_front.sv
// Scan front end: tracks the first smallest valid range and queues it at scan end.
`timescale 1ns / 1ps
module lwf_front #(
  parameter int MAX_SAMPLES = lwf_pkg::MAX_SAMPLES,
  parameter int IDX_W       = $clog2(MAX_SAMPLES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [15:0]      range_mm_i,
  input  logic             last_sample_i,
  output logic             job_push_o,
  output logic [15:0]      job_range_o,
  output logic [IDX_W-1:0] job_index_o
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_SAMPLES - 1);

  logic [15:0]      best_range_q, best_range_d;
  logic [IDX_W-1:0] best_index_q, best_index_d;
  logic [IDX_W-1:0] count_q, count_d;
  logic             best_valid_q, best_valid_d;
  logic [15:0]      new_range;
  logic [IDX_W-1:0] new_index;
  logic             new_valid;
  logic             in_valid;

  assign in_valid = (range_mm_i >= lwf_pkg::VALID_MIN_MM);

  // Running minimum over valid ranges; sample 0 always seeds it
  always_comb begin
    new_range = best_range_q;
    new_index = best_index_q;
    new_valid = best_valid_q;
    if (count_q == '0) begin
      new_range = range_mm_i;
      new_index = '0;
      new_valid = in_valid;
    end else if (in_valid && (!best_valid_q || range_mm_i < best_range_q)) begin
      new_range = range_mm_i;
      new_index = count_q;
      new_valid = 1'b1;
    end
  end

  // Hold, update, or clear at scan end
  always_comb begin
    best_range_d = best_range_q;
    best_index_d = best_index_q;
    best_valid_d = best_valid_q;
    count_d      = count_q;
    if (accept_i) begin
      if (last_sample_i) begin
        best_range_d = '0;
        best_index_d = '0;
        best_valid_d = 1'b0;
        count_d      = '0;
      end else begin
        best_range_d = new_range;
        best_index_d = new_index;
        best_valid_d = new_valid;
        count_d      = (count_q < LastIdx) ? count_q + IDX_W'(1) : count_q;
      end
    end
  end

  assign job_push_o  = accept_i && last_sample_i;
  assign job_range_o = new_range;
  assign job_index_o = new_index;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_range_q <= '0;
      best_index_q <= '0;
      best_valid_q <= 1'b0;
      count_q      <= '0;
    end else begin
      best_range_q <= best_range_d;
      best_index_q <= best_index_d;
      best_valid_q <= best_valid_d;
      count_q      <= count_d;
    end
  end

endmodule

FILE: rtl/core/lwf_back.sv
// Control law back end: bearing, mode choice and fixed-point follow law.
`timescale 1ns / 1ps
module lwf_back #(
  parameter int IDX_W              = 10,
  parameter int SCAN_START_BEARING = lwf_pkg::SCAN_START_BEARING
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lwf_pkg::cfg_t      cfg_i,
  input  logic               job_valid_i,
  input  logic [15:0]        job_range_i,
  input  logic [IDX_W-1:0]   job_index_i,
  output logic               job_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [10:0]        linear_speed_o,
  output logic signed [10:0] turn_rate_o,
  output logic [2:0]         mode_o
);

  // Bearing accumulator base with the rounding half added in
  localparam logic [23:0] AccBase = 24'(SCAN_START_BEARING * 256 + 128);
  localparam logic signed [13:0] MradPerTurn = 14'sd6283;
  localparam logic signed [51:0] TurnLim     = 52'sd268435456000;
  localparam logic signed [39:0] SharpLim    = 40'sd161061273600;
  localparam logic signed [34:0] SpeedLimQ   = 35'sd901120;

  lwf_pkg::back_state_e state_q, state_d;

  logic [15:0]        d_q;
  logic [IDX_W-1:0]   idx_q;
  logic [23:0]        acc_q;
  logic signed [15:0] ar_q;
  logic signed [32:0] p_bg_q, p_tg_q, p_sg_q;
  logic signed [51:0] t1_q, t2_q;
  logic signed [34:0] ls_q;
  logic signed [39:0] ts_c_q;
  logic [19:0]        ls_c_q;
  logic               out_valid_q;
  logic [10:0]        lin_q;
  logic [10:0]        turn_q;
  logic [2:0]         mode_q;

  logic                   slot_free, out_load;
  logic signed [IDX_W+24:0] idx_prod;
  logic signed [15:0]     ar_c;
  logic signed [16:0]     bear_err, derr;
  logic signed [46:0]     t1_c;
  logic signed [51:0]     t2_c, ts_sum;
  logic signed [34:0]     ls_c;
  logic signed [39:0]     ts_round;
  logic                   sharp;
  logic [20:0]            ls_round;
  logic [10:0]            lin_c, turn_c;
  lwf_pkg::mode_e         mode_c;
  logic [16:0]            approach_lim;

  assign slot_free = !out_valid_q || pop_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lwf_pkg::ST_IDLE:     if (job_valid_i) state_d = lwf_pkg::ST_MUL_IDX;
      lwf_pkg::ST_MUL_IDX:  state_d = lwf_pkg::ST_MUL_GAIN;
      lwf_pkg::ST_MUL_GAIN: state_d = lwf_pkg::ST_SCALE;
      lwf_pkg::ST_SCALE:    state_d = lwf_pkg::ST_CLAMP;
      lwf_pkg::ST_CLAMP:    state_d = lwf_pkg::ST_ROUND;
      lwf_pkg::ST_ROUND:    state_d = lwf_pkg::ST_OUT;
      lwf_pkg::ST_OUT:      if (slot_free) state_d = lwf_pkg::ST_IDLE;
      default:              state_d = lwf_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    job_pop_o = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      lwf_pkg::ST_IDLE: job_pop_o = job_valid_i;
      lwf_pkg::ST_OUT:  out_load  = slot_free;
      default: begin
        job_pop_o = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lwf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath arithmetic
  assign idx_prod = $signed({1'b0, idx_q}) * cfg_i.sample_angle_step;
  assign ar_c     = $signed(acc_q[23:8] + 16'h4000);
  assign bear_err = $signed({ar_q[15], ar_q})
                  - (cfg_i.wall_on_left ? 17'sd16384 : -17'sd16384);
  assign derr     = $signed({1'b0, d_q}) - $signed({3'b000, cfg_i.follow_distance});
  assign t1_c     = p_bg_q * MradPerTurn;
  assign t2_c     = cfg_i.wall_on_left ? $signed({{3{p_tg_q[32]}}, p_tg_q, 16'h0000})
                                       : -$signed({{3{p_tg_q[32]}}, p_tg_q, 16'h0000});
  assign ls_c     = $signed({12'h000, cfg_i.cruise_speed, 12'h000})
                  + $signed({{2{p_sg_q[32]}}, p_sg_q});
  assign ts_sum   = t1_q + t2_q;

  // Advance the datapath one step per state
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lwf_pkg::ST_IDLE: begin
        d_q   <= job_range_i;
        idx_q <= job_index_i;
      end
      lwf_pkg::ST_MUL_IDX: begin
        acc_q <= AccBase + idx_prod[23:0];
      end
      lwf_pkg::ST_MUL_GAIN: begin
        ar_q <= ar_c;
      end
      lwf_pkg::ST_SCALE: begin
        p_bg_q <= cfg_i.bearing_gain * bear_err;
        p_tg_q <= cfg_i.offset_turn_gain * derr;
        p_sg_q <= cfg_i.offset_speed_gain * derr;
      end
      lwf_pkg::ST_CLAMP: begin
        t1_q <= {{5{t1_c[46]}}, t1_c};
        t2_q <= t2_c;
        ls_q <= ls_c;
      end
      lwf_pkg::ST_OUT: begin
        // clamp stage feeds the round stage; results held until the slot frees
      end
      default: begin
      end
    endcase
  end

  // Clamp turn and speed ahead of the output state
  always_ff @(posedge clk_i) begin
    if (state_q == lwf_pkg::ST_ROUND) begin
      if (ts_sum > TurnLim) begin
        ts_c_q <= 40'(TurnLim);
      end else if (ts_sum < -TurnLim) begin
        ts_c_q <= 40'(-TurnLim);
      end else begin
        ts_c_q <= ts_sum[39:0];
      end
      if (ls_q < 35'sd0) begin
        ls_c_q <= '0;
      end else if (ls_q > SpeedLimQ) begin
        ls_c_q <= 20'(SpeedLimQ);
      end else begin
        ls_c_q <= ls_q[19:0];
      end
    end
  end

  // Round the follow law and pick the mode
  assign approach_lim = {3'b000, cfg_i.follow_distance} + {3'b000, cfg_i.buffer_distance};
  assign ts_round = ts_c_q + 40'sd134217728;
  assign sharp    = (ts_c_q > SharpLim) || (ts_c_q < -SharpLim);
  assign ls_round = {1'b0, ls_c_q} + (sharp ? 21'd4096 : 21'd2048);

  always_comb begin
    lin_c  = '0;
    turn_c = '0;
    mode_c = lwf_pkg::MODE_FOLLOW;
    priority if (d_q >= lwf_pkg::FAR_MM) begin
      lin_c  = lwf_pkg::SEARCH_SPEED;
      mode_c = lwf_pkg::MODE_NO_OBJECT;
    end else if ({1'b0, d_q} > approach_lim) begin
      if (ar_q > 16'sd8192) begin
        turn_c = lwf_pkg::APPROACH_TURN;
        mode_c = lwf_pkg::MODE_TURN;
      end else if (ar_q < -16'sd8192) begin
        turn_c = -lwf_pkg::APPROACH_TURN;
        mode_c = lwf_pkg::MODE_TURN;
      end else begin
        lin_c  = cfg_i.cruise_speed;
        mode_c = lwf_pkg::MODE_APPROACH;
      end
    end else if (d_q < lwf_pkg::BRAKE_MM) begin
      turn_c = cfg_i.wall_on_left ? lwf_pkg::BRAKE_TURN : -lwf_pkg::BRAKE_TURN;
      mode_c = lwf_pkg::MODE_BRAKE;
    end else begin
      lin_c  = sharp ? {3'b000, ls_round[20:13]} : {2'b00, ls_round[20:12]};
      turn_c = ts_round[38:28];
      mode_c = lwf_pkg::MODE_FOLLOW;
    end
  end

  // Output slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      lin_q  <= lin_c;
      turn_q <= turn_c;
      mode_q <= mode_c;
    end
  end

  assign empty_o        = !out_valid_q;
  assign linear_speed_o = lin_q;
  assign turn_rate_o    = $signed(turn_q);
  assign mode_o         = mode_q;

endmodule

FILE: rtl/core/lidar_wall_follow_controller_core.sv
// Top level of the lidar wall-follow controller: config registers and wiring.
//
// Usage: range samples of one scan enter through the push/full queue port,
// one per cycle whenever full is low; last_sample_i marks the final sample.
// Only a final sample makes a request: the front end keeps the first smallest
// range of at least 200 mm (sample 0 if none) and queues it with its index.
// The back end turns each request into one velocity command on the
// empty/pop port, in order. Samples stream at one per cycle while full is
// low; a command is ready once the back end sequencer has stepped through
// index multiply, bearing, gain multiplies, scaling, clamp and round; it
// takes no new request before it is back in idle. Two requests queue between
// the two halves, and full is high while that queue is full.
// When pop stays low the finished command holds in the output slot, the
// back end finishes the next command and waits, then the request queue fills
// and full rises. Reset empties both queues, clears the scan state and loads
// the default register values. The user must write registers through
// cfg_we_i/cfg_index_i/cfg_data_i only while idle; the block does not check.
`timescale 1ns / 1ps
module lidar_wall_follow_controller_core #(
  parameter int MAX_SAMPLES        = lwf_pkg::MAX_SAMPLES,
  parameter int SCAN_START_BEARING = lwf_pkg::SCAN_START_BEARING
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [15:0]                    range_mm_i,
  input  logic                           last_sample_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [10:0]                    linear_speed_o,
  output logic signed [10:0]             turn_rate_o,
  output logic [2:0]                     mode_o,
  input  logic                           cfg_we_i,
  input  logic [lwf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lwf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int JOB_W = 16 + IDX_W;

  lwf_pkg::cfg_t    cfg_q;
  logic             accept;
  logic             front_push;
  logic [15:0]      front_range;
  logic [IDX_W-1:0] front_index;
  logic [JOB_W-1:0] job_data;
  logic             job_valid, job_pop;

  assign accept = push && !full;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.follow_distance   <= lwf_pkg::FOLLOW_DISTANCE_RST;
      cfg_q.buffer_distance   <= lwf_pkg::BUFFER_DISTANCE_RST;
      cfg_q.cruise_speed      <= lwf_pkg::CRUISE_SPEED_RST;
      cfg_q.bearing_gain      <= $signed(lwf_pkg::BEARING_GAIN_RST);
      cfg_q.offset_turn_gain  <= $signed(lwf_pkg::OFFSET_TURN_GAIN_RST);
      cfg_q.offset_speed_gain <= $signed(lwf_pkg::OFFSET_SPEED_GAIN_RST);
      cfg_q.wall_on_left      <= lwf_pkg::WALL_ON_LEFT_RST;
      cfg_q.sample_angle_step <= $signed(lwf_pkg::SAMPLE_ANGLE_STEP_RST);
    end else if (cfg_we_i) begin
      unique case (lwf_pkg::cfg_reg_e'(cfg_index_i))
        lwf_pkg::CFG_FOLLOW_DISTANCE:   cfg_q.follow_distance   <= cfg_data_i[13:0];
        lwf_pkg::CFG_BUFFER_DISTANCE:   cfg_q.buffer_distance   <= cfg_data_i[13:0];
        lwf_pkg::CFG_CRUISE_SPEED:      cfg_q.cruise_speed      <= cfg_data_i[10:0];
        lwf_pkg::CFG_BEARING_GAIN:      cfg_q.bearing_gain      <= $signed(cfg_data_i[15:0]);
        lwf_pkg::CFG_OFFSET_TURN_GAIN:  cfg_q.offset_turn_gain  <= $signed(cfg_data_i[15:0]);
        lwf_pkg::CFG_OFFSET_SPEED_GAIN: cfg_q.offset_speed_gain <= $signed(cfg_data_i[15:0]);
        lwf_pkg::CFG_WALL_ON_LEFT:      cfg_q.wall_on_left      <= cfg_data_i[0];
        lwf_pkg::CFG_SAMPLE_ANGLE_STEP: cfg_q.sample_angle_step <= $signed(cfg_data_i[23:0]);
        default: begin
        end
      endcase
    end
  end

  lwf_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .range_mm_i    (range_mm_i),
    .last_sample_i (last_sample_i),
    .job_push_o    (front_push),
    .job_range_o   (front_range),
    .job_index_o   (front_index)
  );

  lwf_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (lwf_pkg::JOB_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  ({front_range, front_index}),
    .pop_i   (job_pop),
    .data_o  (job_data),
    .valid_o (job_valid),
    .full_o  (full)
  );

  lwf_back #(
    .IDX_W              (IDX_W),
    .SCAN_START_BEARING (SCAN_START_BEARING)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .job_valid_i    (job_valid),
    .job_range_i    (job_data[JOB_W-1:IDX_W]),
    .job_index_i    (job_data[IDX_W-1:0]),
    .job_pop_o      (job_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .linear_speed_o (linear_speed_o),
    .turn_rate_o    (turn_rate_o),
    .mode_o         (mode_o)
  );

  // A scan-end request never meets a full request queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) front_push |-> !full)
    else $error("scan-end request pushed into a full queue");

  // Turn command stays inside the turn limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (turn_rate_o <= 11'sd1000) && (turn_rate_o >= -11'sd1000))
    else $error("turn command beyond limit");

  // Follow mode speed stays inside the speed limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && mode_o == lwf_pkg::MODE_FOLLOW) |-> linear_speed_o <= lwf_pkg::SPEED_LIMIT)
    else $error("follow speed beyond limit");

  // The back end only pops a request the queue holds
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_pop |-> job_valid)
    else $error("request popped from an empty queue");

endmodule
